FILE: sv/mrt_pkg.sv
// Package for the 63-bit Miller-Rabin primality tester.
// Holds the witness base table and shared widths; depends on nothing.
package mrt_pkg;
    localparam int unsigned MAX_BASES = 12;
    localparam int unsigned WORD_W = 63;
    localparam int unsigned BIDX_W = 4;

    typedef logic [WORD_W-1:0] t_word;

    function automatic logic [5:0] base_at(input logic [BIDX_W-1:0] idx);
        logic [5:0] v;
        case (idx)
            4'd0: v = 6'd2;
            4'd1: v = 6'd3;
            4'd2: v = 6'd5;
            4'd3: v = 6'd7;
            4'd4: v = 6'd11;
            4'd5: v = 6'd13;
            4'd6: v = 6'd17;
            4'd7: v = 6'd19;
            4'd8: v = 6'd23;
            4'd9: v = 6'd29;
            4'd10: v = 6'd31;
            4'd11: v = 6'd37;
            default: v = 6'd2;
        endcase
        return v;
    endfunction
endpackage

FILE: sv/mrt_mulmod.sv
// Iterative modular multiplier: one shift-and-add-mod step per cycle.
// Uses mrt_pkg for the word type.
module mrt_mulmod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mrt_pkg::t_word i_x,
    input  mrt_pkg::t_word i_y,
    input  mrt_pkg::t_word i_m,
    output logic          o_done,
    output mrt_pkg::t_word o_p
);
    logic [5:0]     r_bit, n_bit;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    mrt_pkg::t_word r_acc, n_acc;
    mrt_pkg::t_word r_x, r_y, r_m;
    logic [63:0]    dbl, dsub, add, asub;
    mrt_pkg::t_word acc2;

    always_comb begin
        dbl = {r_acc, 1'b0};
        dsub = dbl - {1'b0, r_m};
        acc2 = (dbl >= {1'b0, r_m}) ? dsub[62:0] : dbl[62:0];
        add = {1'b0, acc2} + {1'b0, r_x};
        asub = add - {1'b0, r_m};
        n_acc = r_acc;
        n_bit = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_bit = 6'd62;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y[r_bit]) begin
                n_acc = (add >= {1'b0, r_m}) ? asub[62:0] : add[62:0];
            end else begin
                n_acc = acc2;
            end
            n_bit = r_bit - 6'd1;
            if (r_bit == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_bit <= n_bit;
        end
        r_acc <= n_acc;
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_m <= i_m;
        end
    end

    assign o_done = r_done;
    assign o_p = r_acc;
endmodule

FILE: sv/primality_test_64bit.sv
// Top level of the Miller-Rabin primality tester: sequencer around mrt_mulmod.
// Depends on mrt_pkg and mrt_mulmod.
// Trivial values finish without any modular product; otherwise each base takes
// up to roughly 126 modular products, over up to twelve bases.
// One candidate at a time; busy stays high until the result strobe.
// Reset is synchronous, active low, and returns the sequencer to idle.
module primality_test_64bit #(
    parameter int unsigned NUM_BASES = 12,
    parameter int unsigned DATA_WIDTH = 63
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_candidate,
    output logic                  o_valid,
    output logic                  o_prime
);
    localparam int unsigned LIMIT = (NUM_BASES > mrt_pkg::MAX_BASES) ?
        mrt_pkg::MAX_BASES : NUM_BASES;
    localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_SPLIT = 4'd2,
        S_BASE = 4'd3, S_EXP = 4'd4, S_EMUL = 4'd5, S_ESQ = 4'd6,
        S_TEST = 4'd7, S_SQ = 4'd8, S_SQW = 4'd9, S_DONE = 4'd10;

    logic [3:0]     r_st, n_st;
    mrt_pkg::t_word r_n, r_d, r_e, r_b, r_x;
    logic [5:0]     r_s, r_r;
    logic [3:0]     r_k;
    logic           r_res, r_valid;
    logic           mul_start, mul_done;
    mrt_pkg::t_word mul_a, mul_b, mul_p, nm1, cand;

    assign cand = mrt_pkg::t_word'({{(64 - DATA_WIDTH){1'b0}}, i_candidate});
    assign nm1 = r_n - 63'd1;

    mrt_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_x(mul_a), .i_y(mul_b), .i_m(r_n), .o_done(mul_done), .o_p(mul_p)
    );

    always_comb begin
        n_st = r_st;
        mul_start = 1'b0;
        mul_a = r_x;
        mul_b = r_b;
        unique case (r_st)
            S_IDLE: if (start) n_st = S_CHECK;
            S_CHECK: begin
                if (r_n < 63'd2 || (r_n > 63'd3 && !r_n[0]) || r_n < 63'd4) n_st = S_DONE;
                else n_st = S_SPLIT;
            end
            S_SPLIT: if (r_d[0]) n_st = S_BASE;
            S_BASE: begin
                if (r_k == 4'(LIMIT)) n_st = S_DONE;
                else n_st = S_EXP;
            end
            S_EXP: begin
                if (r_e == '0) n_st = S_TEST;
                else if (r_e[0]) begin
                    mul_start = 1'b1;
                    n_st = S_EMUL;
                end else begin
                    mul_start = 1'b1;
                    mul_a = r_b;
                    n_st = S_ESQ;
                end
            end
            S_EMUL: if (mul_done) begin
                mul_start = 1'b1;
                mul_a = r_b;
                n_st = S_ESQ;
            end
            S_ESQ: if (mul_done) n_st = S_EXP;
            S_TEST: n_st = S_SQ;
            S_SQ: begin
                mul_start = 1'b1;
                mul_b = r_x;
                n_st = S_SQW;
            end
            S_SQW: if (mul_done) n_st = S_TEST;
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_BASE && r_k != 4'(LIMIT) &&
            {57'd0, mrt_pkg::base_at(r_k)} >= r_n) n_st = S_BASE;
        if (r_st == S_TEST) begin
            if (r_r == 6'd0 && (r_x == 63'd1 || r_x == nm1)) n_st = S_BASE;
            else if (r_r != 6'd0 && r_x == nm1) n_st = S_BASE;
            else if (r_r + 6'd1 >= r_s) n_st = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_valid <= (r_st == S_DONE);
        end
        unique case (r_st)
            S_IDLE: if (start) begin
                r_n <= cand;
                r_d <= cand - 63'd1;
                r_s <= '0;
                r_k <= '0;
                r_res <= 1'b1;
            end
            S_CHECK: if (r_n < 63'd2 || (r_n > 63'd3 && !r_n[0])) r_res <= 1'b0;
            S_SPLIT: if (!r_d[0]) begin
                r_d <= r_d >> 1;
                r_s <= r_s + 6'd1;
            end
            S_BASE: begin
                r_k <= r_k + 4'd1;
                r_x <= 63'd1;
                r_e <= r_d;
                r_r <= '0;
                r_b <= {57'd0, mrt_pkg::base_at(r_k)};
            end
            S_EMUL: if (mul_done) r_x <= mul_p;
            S_ESQ: if (mul_done) begin
                r_b <= mul_p;
                r_e <= r_e >> 1;
            end
            S_EXP: if (r_e != '0 && !r_e[0]) r_e <= r_e;
            S_TEST: begin
                if (!(r_r == 6'd0 && (r_x == 63'd1 || r_x == nm1)) &&
                    !(r_r != 6'd0 && r_x == nm1) && r_r + 6'd1 >= r_s) r_res <= 1'b0;
            end
            S_SQW: if (mul_done) begin
                r_x <= mul_p;
                r_r <= r_r + 6'd1;
            end
            default: ;
        endcase
    end

    assign busy = (r_st != S_IDLE);
    assign o_valid = r_valid;
    assign o_prime = r_res;

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("strobe while busy");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transfer not taken");
endmodule
